// File: src/kfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package kfb_pkg;

  localparam int KEY_BYTES = 16;
  localparam int FRAME_LEN = KEY_BYTES + 9;
  localparam int IDX_W     = 5;

  localparam logic [7:0] FRAME_MAGIC = 8'h55;
  localparam logic [7:0] FRAME_LEN_BYTE = 8'(FRAME_LEN - 2);

  localparam logic [IDX_W-1:0] POS_MAGIC  = IDX_W'(0);
  localparam logic [IDX_W-1:0] POS_LEN    = IDX_W'(1);
  localparam logic [IDX_W-1:0] POS_KEY0   = IDX_W'(2);
  localparam logic [IDX_W-1:0] POS_KEYN   = IDX_W'(2 + KEY_BYTES - 1);
  localparam logic [IDX_W-1:0] POS_USE_LO = IDX_W'(2 + KEY_BYTES);
  localparam logic [IDX_W-1:0] POS_USE_HI = IDX_W'(3 + KEY_BYTES);
  localparam logic [IDX_W-1:0] POS_TARGET = IDX_W'(4 + KEY_BYTES);
  localparam logic [IDX_W-1:0] POS_SEQ    = IDX_W'(5 + KEY_BYTES);
  localparam logic [IDX_W-1:0] POS_WHEEL  = IDX_W'(6 + KEY_BYTES);
  localparam logic [IDX_W-1:0] POS_ZERO   = IDX_W'(7 + KEY_BYTES);
  localparam logic [IDX_W-1:0] POS_XOR    = IDX_W'(FRAME_LEN - 1);

  localparam logic [2:0] ACT_REPORT  = 3'd0;
  localparam logic [2:0] ACT_TICK    = 3'd1;
  localparam logic [2:0] ACT_DONE    = 3'd2;
  localparam logic [2:0] ACT_DISABLE = 3'd3;
  localparam logic [2:0] ACT_ENABLE  = 3'd4;

  localparam logic [2:0] CFG_TARGET   = 3'd0;
  localparam logic [2:0] CFG_REL_CNT  = 3'd1;
  localparam logic [2:0] CFG_REL_GAP  = 3'd2;
  localparam logic [2:0] CFG_VOL_UP   = 3'd3;
  localparam logic [2:0] CFG_VOL_DOWN = 3'd4;

  localparam logic signed [7:0] VOL_MAX = 8'sd127;
  localparam logic signed [7:0] VOL_MIN = -8'sd127;

  typedef struct packed {
    logic [8*KEY_BYTES-1:0] keys;
    logic [15:0]            usage;
    logic [7:0]             target;
    logic [7:0]             seq;
    logic [7:0]             wheel;
  } frame_desc_t;

endpackage
`default_nettype wire

// File: src/kfb_front.sv
`timescale 1ns / 1ps
`default_nettype none
module kfb_front
  import kfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  action,
  input  wire logic [63:0] keys_low,
  input  wire logic [63:0] keys_high,
  input  wire logic [15:0] media_usage,
  input  wire logic signed [7:0] volume_delta,
  input  wire logic signed [7:0] wheel_step,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        q_full,
  output logic             q_push,
  output frame_desc_t      q_data
);

  logic [7:0]  frame_target;
  logic [3:0]  release_frame_count;
  logic [3:0]  release_gap;
  logic [15:0] volume_up_code;
  logic [15:0] volume_down_code;

  logic [8*KEY_BYTES-1:0] key_map, key_map_next;
  logic [15:0] pending_usage, pending_usage_next;
  logic [15:0] last_input_usage, last_input_usage_next;
  logic signed [7:0] volume_pending, volume_pending_next;
  logic usage_release_pending, usage_release_pending_next;
  logic signed [7:0] wheel_pending, wheel_pending_next;
  logic [7:0] sequence_number, sequence_number_next;
  logic tx_enabled, tx_enabled_next;
  logic release_active, release_active_next;
  logic [3:0] release_left, release_left_next;
  logic [3:0] gap_left, gap_left_next;
  logic release_in_flight, release_in_flight_next;

  logic take;
  logic emit;
  logic [15:0] emit_usage;
  logic [7:0] emit_wheel;
  logic signed [8:0] vol_sum;

  assign in_ready = !q_full;
  assign take = in_valid && in_ready;
  assign vol_sum = 9'(volume_pending) + 9'(volume_delta);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_target        <= 8'd0;
      release_frame_count <= 4'd4;
      release_gap         <= 4'd2;
      volume_up_code      <= 16'd233;
      volume_down_code    <= 16'd234;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET:   frame_target <= cfg_data[7:0];
        CFG_REL_CNT:  release_frame_count <= cfg_data[3:0];
        CFG_REL_GAP:  release_gap <= cfg_data[3:0];
        CFG_VOL_UP:   volume_up_code <= cfg_data;
        CFG_VOL_DOWN: volume_down_code <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    key_map_next               = key_map;
    pending_usage_next         = pending_usage;
    last_input_usage_next      = last_input_usage;
    volume_pending_next        = volume_pending;
    usage_release_pending_next = usage_release_pending;
    wheel_pending_next         = wheel_pending;
    sequence_number_next       = sequence_number;
    tx_enabled_next            = tx_enabled;
    release_active_next        = release_active;
    release_left_next          = release_left;
    gap_left_next              = gap_left;
    release_in_flight_next     = release_in_flight;
    emit       = 1'b0;
    emit_usage = 16'd0;
    emit_wheel = 8'd0;

    if (take) begin
      unique case (action)
        ACT_REPORT: begin
          if (!release_active) begin
            key_map_next = {keys_high, keys_low};
            if (media_usage != 16'd0 && last_input_usage == 16'd0 &&
                pending_usage == 16'd0) begin
              pending_usage_next = media_usage;
            end
            last_input_usage_next = media_usage;
            if (vol_sum > 9'sd127) begin
              volume_pending_next = VOL_MAX;
            end else if (vol_sum < -9'sd127) begin
              volume_pending_next = VOL_MIN;
            end else begin
              volume_pending_next = vol_sum[7:0];
            end
            if (wheel_step > 8'sd0 && wheel_pending < VOL_MAX) begin
              wheel_pending_next = wheel_pending + 8'sd1;
            end else if (wheel_step < 8'sd0 && wheel_pending > VOL_MIN) begin
              wheel_pending_next = wheel_pending - 8'sd1;
            end
          end
        end
        ACT_TICK: begin
          if (tx_enabled) begin
            emit = 1'b1;
          end else if (release_active && !release_in_flight) begin
            if (gap_left != 4'd0) begin
              gap_left_next = gap_left - 4'd1;
            end else if (release_left != 4'd0) begin
              release_left_next      = release_left - 4'd1;
              release_in_flight_next = 1'b1;
              emit = 1'b1;
            end
          end
        end
        ACT_DONE: begin
          if (release_active && release_in_flight) begin
            release_in_flight_next = 1'b0;
            if (release_left == 4'd0) begin
              release_active_next = 1'b0;
            end else begin
              gap_left_next = (release_gap != 4'd0) ? release_gap - 4'd1 : 4'd0;
            end
          end
        end
        ACT_DISABLE: begin
          if (!release_active && tx_enabled) begin
            key_map_next               = '0;
            pending_usage_next         = 16'd0;
            last_input_usage_next      = 16'd0;
            volume_pending_next        = 8'sd0;
            usage_release_pending_next = 1'b0;
            wheel_pending_next         = 8'sd0;
            tx_enabled_next            = 1'b0;
            release_left_next          = release_frame_count;
            release_active_next        = (release_frame_count != 4'd0);
            gap_left_next              = 4'd0;
            release_in_flight_next     = 1'b0;
          end
        end
        ACT_ENABLE: begin
          release_active_next    = 1'b0;
          release_left_next      = 4'd0;
          gap_left_next          = 4'd0;
          release_in_flight_next = 1'b0;
          tx_enabled_next        = 1'b1;
        end
        default: ;
      endcase
    end

    if (emit) begin
      if (usage_release_pending) begin
        usage_release_pending_next = 1'b0;
      end else if (pending_usage != 16'd0) begin
        emit_usage                 = pending_usage;
        pending_usage_next         = 16'd0;
        usage_release_pending_next = 1'b1;
      end else if (volume_pending > 8'sd0) begin
        volume_pending_next        = volume_pending - 8'sd1;
        emit_usage                 = volume_up_code;
        usage_release_pending_next = 1'b1;
      end else if (volume_pending < 8'sd0) begin
        volume_pending_next        = volume_pending + 8'sd1;
        emit_usage                 = volume_down_code;
        usage_release_pending_next = 1'b1;
      end
      if (wheel_pending > 8'sd0) begin
        wheel_pending_next = wheel_pending - 8'sd1;
        emit_wheel         = 8'h01;
      end else if (wheel_pending < 8'sd0) begin
        wheel_pending_next = wheel_pending + 8'sd1;
        emit_wheel         = 8'hFF;
      end
      sequence_number_next = sequence_number + 8'd1;
    end
  end

  assign q_push        = emit;
  assign q_data.keys   = key_map;
  assign q_data.usage  = emit_usage;
  assign q_data.target = frame_target;
  assign q_data.seq    = sequence_number;
  assign q_data.wheel  = emit_wheel;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_map               <= '0;
      pending_usage         <= 16'd0;
      last_input_usage      <= 16'd0;
      volume_pending        <= 8'sd0;
      usage_release_pending <= 1'b0;
      wheel_pending         <= 8'sd0;
      sequence_number       <= 8'd0;
      tx_enabled            <= 1'b1;
      release_active        <= 1'b0;
      release_left          <= 4'd0;
      gap_left              <= 4'd0;
      release_in_flight     <= 1'b0;
    end else begin
      key_map               <= key_map_next;
      pending_usage         <= pending_usage_next;
      last_input_usage      <= last_input_usage_next;
      volume_pending        <= volume_pending_next;
      usage_release_pending <= usage_release_pending_next;
      wheel_pending         <= wheel_pending_next;
      sequence_number       <= sequence_number_next;
      tx_enabled            <= tx_enabled_next;
      release_active        <= release_active_next;
      release_left          <= release_left_next;
      gap_left              <= gap_left_next;
      release_in_flight     <= release_in_flight_next;
    end
  end

endmodule
`default_nettype wire

// File: src/kfb_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module kfb_queue
  import kfb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire frame_desc_t push_data,
  output logic       full,
  input  wire logic  pop,
  output logic       head_valid,
  output frame_desc_t head_data
);

  frame_desc_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_data  = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

// File: src/kfb_back.sv
`timescale 1ns / 1ps
`default_nettype none
module kfb_back
  import kfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        head_valid,
  input  wire frame_desc_t head_data,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       frame_byte,
  output logic [IDX_W-1:0] byte_index,
  output logic             last
);

  logic [IDX_W-1:0] idx;
  logic [7:0]       xor_acc;
  logic [7:0]       byte_sel;
  logic [IDX_W-1:0] key_off;
  logic [8*KEY_BYTES-1:0] key_shift;
  logic             advance;
  logic             is_last;

  assign advance   = !out_valid || out_ready;
  assign is_last   = (idx == POS_XOR);
  assign pop       = advance && head_valid && is_last;
  assign key_off   = idx - POS_KEY0;
  assign key_shift = head_data.keys >> {key_off[3:0], 3'b000};

  always_comb begin
    case (idx) inside
      POS_MAGIC:             byte_sel = FRAME_MAGIC;
      POS_LEN:               byte_sel = FRAME_LEN_BYTE;
      [POS_KEY0:POS_KEYN]:   byte_sel = key_shift[7:0];
      POS_USE_LO:            byte_sel = head_data.usage[7:0];
      POS_USE_HI:            byte_sel = head_data.usage[15:8];
      POS_TARGET:            byte_sel = head_data.target;
      POS_SEQ:               byte_sel = head_data.seq;
      POS_WHEEL:             byte_sel = head_data.wheel;
      POS_XOR:               byte_sel = xor_acc;
      default:               byte_sel = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= POS_MAGIC;
    end else if (advance) begin
      out_valid <= head_valid;
      if (head_valid) begin
        idx <= is_last ? POS_MAGIC : idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && head_valid) begin
      frame_byte <= byte_sel;
      byte_index <= idx;
      last       <= is_last;
      xor_acc    <= (idx == POS_MAGIC) ? byte_sel : xor_acc ^ byte_sel;
    end
  end

endmodule
`default_nettype wire

// File: src/keyboard_report_frame_builder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A tick that emits is written into the queue, and when the back end is idle frame
// byte 0 is then registered at the back end output.
// One frame byte per cycle while out_ready holds, set by the byte sequencer of the
// back end; a frame is 25 bytes.
// Up to two frames wait in the queue; input stalls only when it is full.
// Reset: synchronous, active high; clears report state, queue and output,
// enables transmission and loads the register defaults.
module keyboard_report_frame_builder_core
  import kfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  action,
  input  wire logic [63:0] keys_low,
  input  wire logic [63:0] keys_high,
  input  wire logic [15:0] media_usage,
  input  wire logic signed [7:0] volume_delta,
  input  wire logic signed [7:0] wheel_step,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       frame_byte,
  output logic [4:0]       byte_index,
  output logic             last
);

  logic        q_full;
  logic        q_push;
  frame_desc_t q_data;
  logic        q_pop;
  logic        q_head_valid;
  frame_desc_t q_head;

  kfb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .keys_low     (keys_low),
    .keys_high    (keys_high),
    .media_usage  (media_usage),
    .volume_delta (volume_delta),
    .wheel_step   (wheel_step),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_data)
  );

  kfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head)
  );

  kfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_data  (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .byte_index (byte_index),
    .last       (last)
  );

endmodule
`default_nettype wire

// File: src/kfb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module kfb_checker
  import kfb_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] frame_byte,
  input wire logic [4:0] byte_index,
  input wire logic       last
);

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (byte_index == POS_XOR)))
    else $error("last flag does not match final byte position");

  a_magic_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_index == POS_MAGIC |-> frame_byte == FRAME_MAGIC)
    else $error("frame does not open with magic byte");

  a_bytes_contiguous: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=>
      out_valid && byte_index == $past(byte_index) + 5'd1)
    else $error("frame bytes not contiguous");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(frame_byte) && $stable(byte_index))
    else $error("stalled output beat changed");

endmodule

bind keyboard_report_frame_builder_core kfb_checker u_kfb_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .frame_byte (frame_byte),
  .byte_index (byte_index),
  .last       (last)
);
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import kfb_pkg::*;

  localparam int SETTLE_CYCLES  = 12;
  localparam int LONG_HOLD      = 400;
  localparam int TIMEOUT_CYCLES = 200000;

  class frame_tracker;
    typedef struct {
      logic [7:0] data;
      logic [4:0] pos;
      logic       fin;
    } frame_beat_t;

    frame_beat_t expected_bytes[$];
    int          errors;

    logic [7:0]  target_byte;
    logic [3:0]  release_count;
    logic [3:0]  release_spacing;
    logic [15:0] vol_up_usage;
    logic [15:0] vol_down_usage;

    logic [63:0] key_map[2];
    logic [15:0] pending_usage;
    logic [15:0] prev_usage;
    int          vol_steps;
    int          wheel_steps;
    bit          release_due;
    logic [7:0]  seq_num;
    bit          tx_on;
    bit          burst_on;
    int          frames_left;
    int          gap_ticks;
    bit          frame_out;

    function new();
      errors          = 0;
      target_byte     = 8'd0;
      release_count   = 4'd4;
      release_spacing = 4'd2;
      vol_up_usage    = 16'd233;
      vol_down_usage  = 16'd234;
      clear_report();
      seq_num     = 8'd0;
      tx_on       = 1'b1;
      burst_on    = 1'b0;
      frames_left = 0;
      gap_ticks   = 0;
      frame_out   = 1'b0;
    endfunction

    function void clear_report();
      key_map[0]    = '0;
      key_map[1]    = '0;
      pending_usage = '0;
      prev_usage    = '0;
      vol_steps     = 0;
      wheel_steps   = 0;
      release_due   = 1'b0;
    endfunction

    function int bytes_owed();
      return expected_bytes.size();
    endfunction

    function void write_reg(input logic [2:0] idx, input logic [15:0] val);
      case (idx)
        CFG_TARGET:   target_byte = val[7:0];
        CFG_REL_CNT:  release_count = val[3:0];
        CFG_REL_GAP:  release_spacing = val[3:0];
        CFG_VOL_UP:   vol_up_usage = val;
        CFG_VOL_DOWN: vol_down_usage = val;
        default: ;
      endcase
    endfunction

    function void build_frame();
      logic [7:0]  fb[FRAME_LEN];
      logic [15:0] usage;
      logic [7:0]  wheel;
      logic [7:0]  sum;
      frame_beat_t beat;
      usage = '0;
      wheel = '0;
      sum   = '0;
      if (release_due) begin
        release_due = 1'b0;
      end else if (pending_usage != 0) begin
        usage         = pending_usage;
        pending_usage = '0;
        release_due   = 1'b1;
      end else if (vol_steps > 0) begin
        vol_steps--;
        usage       = vol_up_usage;
        release_due = 1'b1;
      end else if (vol_steps < 0) begin
        vol_steps++;
        usage       = vol_down_usage;
        release_due = 1'b1;
      end
      if (wheel_steps > 0) begin
        wheel_steps--;
        wheel = 8'h01;
      end else if (wheel_steps < 0) begin
        wheel_steps++;
        wheel = 8'hFF;
      end
      fb[POS_MAGIC] = FRAME_MAGIC;
      fb[POS_LEN]   = FRAME_LEN_BYTE;
      for (int i = 0; i < KEY_BYTES; i++)
        fb[POS_KEY0 + i] = key_map[i / 8][8 * (i % 8) +: 8];
      fb[POS_USE_LO] = usage[7:0];
      fb[POS_USE_HI] = usage[15:8];
      fb[POS_TARGET] = target_byte;
      fb[POS_SEQ]    = seq_num;
      seq_num++;
      fb[POS_WHEEL]  = wheel;
      fb[POS_ZERO]   = 8'h00;
      for (int i = 0; i < FRAME_LEN - 1; i++)
        sum ^= fb[i];
      fb[POS_XOR] = sum;
      for (int i = 0; i < FRAME_LEN; i++) begin
        beat.data = fb[i];
        beat.pos  = 5'(i);
        beat.fin  = (i == FRAME_LEN - 1);
        expected_bytes.push_back(beat);
      end
    endfunction

    function void take_item(input logic [2:0] act, input logic [63:0] kl,
                            input logic [63:0] kh, input logic [15:0] mu,
                            input logic signed [7:0] vd, input logic signed [7:0] ws);
      int level;
      case (act)
        ACT_REPORT: begin
          if (!burst_on) begin
            key_map[0] = kl;
            key_map[1] = kh;
            if (mu != 0 && prev_usage == 0 && pending_usage == 0)
              pending_usage = mu;
            prev_usage = mu;
            level = vol_steps + int'(vd);
            if (level > VOL_MAX) level = VOL_MAX;
            if (level < VOL_MIN) level = VOL_MIN;
            vol_steps = level;
            if (ws > 0 && wheel_steps < VOL_MAX)
              wheel_steps++;
            else if (ws < 0 && wheel_steps > VOL_MIN)
              wheel_steps--;
          end
        end
        ACT_TICK: begin
          if (tx_on) begin
            build_frame();
          end else if (burst_on && !frame_out) begin
            if (gap_ticks != 0) begin
              gap_ticks--;
            end else if (frames_left != 0) begin
              frames_left--;
              frame_out = 1'b1;
              build_frame();
            end
          end
        end
        ACT_DONE: begin
          if (burst_on && frame_out) begin
            frame_out = 1'b0;
            if (frames_left == 0)
              burst_on = 1'b0;
            else
              gap_ticks = (release_spacing > 0) ? int'(release_spacing) - 1 : 0;
          end
        end
        ACT_DISABLE: begin
          if (!burst_on && tx_on) begin
            clear_report();
            tx_on       = 1'b0;
            frames_left = release_count;
            burst_on    = (release_count != 0);
            gap_ticks   = 0;
            frame_out   = 1'b0;
          end
        end
        ACT_ENABLE: begin
          burst_on    = 1'b0;
          frames_left = 0;
          gap_ticks   = 0;
          frame_out   = 1'b0;
          tx_on       = 1'b1;
        end
        default: ;
      endcase
    endfunction

    function void check_byte(input logic [7:0] data, input logic [4:0] pos, input logic fin);
      frame_beat_t want;
      if (expected_bytes.size() == 0) begin
        $error("frame_byte %h at byte_index %0d with no frame pending", data, pos);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (data !== want.data) begin
        $error("frame_byte: expected %h, got %h", want.data, data);
        errors++;
      end
      if (pos !== want.pos) begin
        $error("byte_index: expected %0d, got %0d", want.pos, pos);
        errors++;
      end
      if (fin !== want.fin) begin
        $error("last: expected %b, got %b", want.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        action = '0;
  logic [63:0]       keys_low = '0;
  logic [63:0]       keys_high = '0;
  logic [15:0]       media_usage = '0;
  logic signed [7:0] volume_delta = '0;
  logic signed [7:0] wheel_step = '0;
  logic              cfg_we = 1'b0;
  logic [2:0]        cfg_index = '0;
  logic [15:0]       cfg_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        frame_byte;
  logic [4:0]        byte_index;
  logic              last;

  frame_tracker sb = new();
  bit           offering = 1'b0;
  bit           hold_req = 1'b0;
  int           burst_left = 0;
  int           items_sent = 0;
  int           cur_cnt = 4;
  int           cur_gap = 2;

  keyboard_report_frame_builder_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .keys_low     (keys_low),
    .keys_high    (keys_high),
    .media_usage  (media_usage),
    .volume_delta (volume_delta),
    .wheel_step   (wheel_step),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_byte   (frame_byte),
    .byte_index   (byte_index),
    .last         (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.take_item(action, keys_low, keys_high, media_usage, volume_delta, wheel_step);
      if (out_valid && out_ready)
        sb.check_byte(frame_byte, byte_index, last);
    end
  end

  initial begin : rx_side
    int run_left;
    int mode;
    int hold_left;
    bit hold_seen;
    run_left  = 0;
    mode      = 0;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (run_left == 0) begin
        mode     = $urandom_range(0, 3);
        run_left = $urandom_range(4, 50);
      end
      run_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  task automatic send(input logic [2:0] act, input logic [63:0] kl, input logic [63:0] kh,
                      input logic [15:0] mu, input logic signed [7:0] vd,
                      input logic signed [7:0] ws);
    int gap;
    in_valid     <= 1'b1;
    offering     = 1'b1;
    action       <= act;
    keys_low     <= kl;
    keys_high    <= kh;
    media_usage  <= mu;
    volume_delta <= vd;
    wheel_step   <= ws;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic offer(input logic [2:0] act);
    logic [15:0]       mu;
    logic signed [7:0] vd;
    logic signed [7:0] ws;
    case ($urandom_range(0, 3))
      0, 1: mu = '0;
      2: mu = 16'($urandom_range(1, 8));
      default: mu = 16'($urandom);
    endcase
    vd = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6) - 3);
    ws = ($urandom_range(0, 2) == 0) ? 8'sd0 : 8'($urandom);
    send(act, {$urandom, $urandom}, {$urandom, $urandom}, mu, vd, ws);
  endtask

  task automatic drain();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    do @(posedge clk); while (sb.bytes_owed() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_config(input logic [7:0] tid, input logic [3:0] cnt, input logic [3:0] gap,
                            input logic [15:0] up, input logic [15:0] down);
    cfg_write(CFG_TARGET, 16'(tid));
    cfg_write(CFG_REL_CNT, 16'(cnt));
    cfg_write(CFG_REL_GAP, 16'(gap));
    cfg_write(CFG_VOL_UP, up);
    cfg_write(CFG_VOL_DOWN, down);
    cfg_we <= 1'b0;
    cur_cnt = cnt;
    cur_gap = gap;
  endtask

  task automatic release_burst();
    int frames;
    int most;
    most = (cur_gap > 0) ? 20 / cur_gap : 20;
    if (most < 1) most = 1;
    if (most > cur_cnt) most = cur_cnt;
    frames = ($urandom_range(0, 1) != 0) ? most : $urandom_range(1, most);
    offer(ACT_DISABLE);
    for (int f = 0; f < frames; f++) begin
      if (f != 0) repeat (cur_gap - 1) offer(ACT_TICK);
      offer(ACT_TICK);
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0: offer(ACT_REPORT);
          1: offer(ACT_TICK);
          default: offer(ACT_DISABLE);
        endcase
      end
      offer(ACT_DONE);
    end
    offer(ACT_ENABLE);
  endtask

  task automatic run_random(input int n);
    int stop_at;
    int pick;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        repeat ($urandom_range(1, 4)) offer(ACT_REPORT);
        repeat ($urandom_range(1, 3)) offer(ACT_TICK);
      end else if (pick < 8) begin
        release_burst();
      end else begin
        offer(3'($urandom_range(0, 7)));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    offer(ACT_TICK);
    send(ACT_REPORT, '1, '1, 16'hFFFF, 8'sd127, 8'sd127);
    send(ACT_REPORT, '0, 64'h8000_0000_0000_0001, 16'hFFFF, 8'sd127, 8'h80);
    offer(ACT_TICK);
    offer(ACT_TICK);
    send(ACT_REPORT, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 16'h0000, 8'h80, 8'sd0);
    offer(ACT_TICK);
    send(ACT_REPORT, 64'h5A5A_5A5A_A5A5_A5A5, '0, 16'h00E2, 8'sd0, 8'sd1);
    offer(ACT_DISABLE);
    send(ACT_REPORT, '1, '1, 16'h1234, 8'sd5, 8'sd1);
    offer(ACT_TICK);
    offer(ACT_TICK);
    offer(ACT_DONE);
    offer(ACT_TICK);
    offer(ACT_TICK);
    offer(ACT_DISABLE);
    offer(ACT_DONE);
    repeat (2) begin
      offer(ACT_TICK);
      offer(ACT_TICK);
      offer(ACT_DONE);
    end
    offer(ACT_TICK);
    send(ACT_REPORT, 64'h00FF_00FF_00FF_00FF, 64'hFF00_FF00_FF00_FF00, 16'h0042, -8'sd2, -8'sd1);
    offer(ACT_DISABLE);
    offer(ACT_DONE);
    offer(ACT_ENABLE);
    offer(ACT_TICK);
    drain();

    set_config(8'hFF, 4'd15, 4'd15, 16'hFFFF, 16'h0000);
    run_random(30);
    drain();

    set_config(8'h00, 4'd1, 4'd1, 16'h0000, 16'hFFFF);
    offer(ACT_ENABLE);
    hold_req = ~hold_req;
    repeat (12) offer(ACT_TICK);
    run_random(30);
    drain();

    set_config(8'($urandom), 4'($urandom_range(2, 6)), 4'($urandom_range(1, 4)),
               16'($urandom), 16'($urandom));
    run_random(30);
    drain();

    if (sb.errors == 0 && sb.bytes_owed() == 0)
      $display("[keyboard_report_frame_builder_core] OK");
    else
      $display("[keyboard_report_frame_builder_core] ERROR");
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("[keyboard_report_frame_builder_core] ERROR");
    $finish;
  end

endmodule
